// ===== design/qphs_pkg.sv =====
`timescale 1ns / 1ps

package qphs_pkg;

  // Slot store geometry
  localparam int CAPACITY = 1024;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CNT_W    = IDX_W + 1;

  // Field widths
  localparam int OP_W     = 2;
  localparam int KEY_W    = 31;
  localparam int STAT_W   = 2;
  localparam int TSIZE_W  = 11;
  localparam int SAT_W    = (TSIZE_W > CNT_W) ? TSIZE_W : CNT_W;

  // Table size bounds and reset value
  localparam int MIN_SIZE   = 3;
  localparam int TSIZE_RST  = 1021;

  // Remainder unit: radix 2^DIV_BITS restoring steps over a padded key
  localparam int DIV_BITS  = 4;
  localparam int DIV_W     = ((KEY_W + DIV_BITS - 1) / DIV_BITS) * DIV_BITS;
  localparam int DIV_STEPS = DIV_W / DIV_BITS;
  localparam int DIVC_W    = (DIV_STEPS > 1) ? $clog2(DIV_STEPS) : 1;

  typedef enum logic [OP_W-1:0] {
    OP_INSERT = 2'd0,
    OP_DELETE = 2'd1,
    OP_SEARCH = 2'd2
  } op_t;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK        = 2'd0,
    STAT_NOT_FOUND = 2'd1,
    STAT_NO_FREE   = 2'd2,
    STAT_INVALID   = 2'd3
  } status_t;

  typedef enum logic [4:0] {
    ST_CLEAR = 5'b00001,
    ST_IDLE  = 5'b00010,
    ST_DIV   = 5'b00100,
    ST_PROBE = 5'b01000,
    ST_RESP  = 5'b10000
  } state_t;

endpackage

// ===== design/qphs_ram.sv =====
`timescale 1ns / 1ps

module qphs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== design/quadratic_probe_hash_set.sv =====
`timescale 1ns / 1ps

// Channel  Direction  Handshake               Payload
// in       input      in_valid / in_ready     in_op, in_key
// out      output     out_valid / out_ready   out_status, out_slot_index, out_occupancy,
//                                             out_over_half
// cfg      input      cfg_valid / cfg_ready   cfg_data (table size)
//
// One request at a time. A transfer on the input passes through the key-mod-size
// remainder unit (4 quotient bits per cycle), then one slot store read per probe issued
// back to back; the read data is registered in the store, and the result is then posted
// to the output register. A zero key or an unknown op goes straight to the result.
// Reset (rst_n low, synchronous) starts a clearing pass over all 1024 slots of the slot
// store; in_ready stays low until it ends, cfg writes are taken throughout.
// The result sits in an output register; a stalled out channel holds the next request
// in its result state, and no new input transfer is taken meanwhile.

module quadratic_probe_hash_set (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [qphs_pkg::OP_W-1:0]     in_op,
  input  logic [qphs_pkg::KEY_W-1:0]    in_key,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [qphs_pkg::STAT_W-1:0]   out_status,
  output logic [qphs_pkg::IDX_W-1:0]    out_slot_index,
  output logic [qphs_pkg::CNT_W-1:0]    out_occupancy,
  output logic                          out_over_half,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [qphs_pkg::TSIZE_W-1:0]  cfg_data
);
  import qphs_pkg::*;

  // Saturate the programmed size to the usable range.
  function automatic logic [CNT_W-1:0] eff_size(input logic [TSIZE_W-1:0] cfg);
    logic [SAT_W-1:0] v;
    v = SAT_W'(cfg);
    if (v < SAT_W'(MIN_SIZE)) v = SAT_W'(MIN_SIZE);
    if (v > SAT_W'(CAPACITY)) v = SAT_W'(CAPACITY);
    return v[CNT_W-1:0];
  endfunction

  // DIV_BITS restoring steps: shift in one key bit, subtract the size when it fits.
  function automatic logic [IDX_W-1:0] div_step(input logic [IDX_W-1:0]    rem,
                                                input logic [DIV_BITS-1:0] bits,
                                                input logic [CNT_W-1:0]    s);
    logic [CNT_W-1:0] t;
    logic [IDX_W-1:0] r;
    r = rem;
    for (int b = DIV_BITS - 1; b >= 0; b--) begin
      t = {r, bits[b]};
      if (t >= s) t = t - s;
      r = t[IDX_W-1:0];
    end
    return r;
  endfunction

  // Control and data registers
  state_t               state_r, state_nxt;
  logic [TSIZE_W-1:0]   tsize_r;
  logic [CNT_W-1:0]     filled_r, filled_nxt;
  logic [IDX_W-1:0]     clr_addr_r, clr_addr_nxt;
  logic [OP_W-1:0]      op_r, op_nxt;
  logic [KEY_W-1:0]     key_r, key_nxt;
  logic [CNT_W-1:0]     s_r, s_nxt;
  logic [DIV_W-1:0]     kq_r, kq_nxt;
  logic [IDX_W-1:0]     rem_r, rem_nxt;
  logic [DIVC_W-1:0]    div_cnt_r, div_cnt_nxt;
  logic [IDX_W-1:0]     pidx_r, pidx_nxt;
  logic [CNT_W-1:0]     d_r, d_nxt;
  logic [CNT_W-1:0]     iss_cnt_r, iss_cnt_nxt;
  logic                 p1_vld_r, p1_vld_nxt;
  logic [IDX_W-1:0]     p1_idx_r, p1_idx_nxt;
  logic [STAT_W-1:0]    res_status_r, res_status_nxt;
  logic [IDX_W-1:0]     res_slot_r, res_slot_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic [STAT_W-1:0]    out_status_r, out_status_nxt;
  logic [IDX_W-1:0]     out_slot_r, out_slot_nxt;
  logic [CNT_W-1:0]     out_occ_r, out_occ_nxt;
  logic                 out_half_r, out_half_nxt;

  // Slot store port signals
  logic                 ram_we;
  logic [IDX_W-1:0]     ram_waddr;
  logic [KEY_W-1:0]     ram_wdata;
  logic [KEY_W-1:0]     ram_rdata;

  logic                 in_xfer;
  logic                 match;
  logic                 hit;
  logic [IDX_W-1:0]     rem_step;
  logic [CNT_W-1:0]     idx_sum;
  logic [CNT_W-1:0]     d_sum;

  qphs_ram #(
    .WIDTH (KEY_W),
    .DEPTH (CAPACITY)
  ) u_slot_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (pidx_r),
    .rdata (ram_rdata)
  );

  assign in_ready  = (state_r == ST_IDLE);
  assign in_xfer   = in_valid && in_ready;
  assign cfg_ready = 1'b1;

  assign out_valid      = out_valid_r;
  assign out_status     = out_status_r;
  assign out_slot_index = out_slot_r;
  assign out_occupancy  = out_occ_r;
  assign out_over_half  = out_half_r;

  // Probe data returns in the cycle after its address; insert looks for an empty slot.
  assign match    = (op_r == OP_INSERT) ? (ram_rdata == '0) : (ram_rdata == key_r);
  assign hit      = p1_vld_r && match;
  assign rem_step = div_step(rem_r, kq_r[DIV_W-1 -: DIV_BITS], s_r);

  // Next probe: idx += (2i+1) mod S, and the odd step grows by 2, both kept below S.
  always_comb begin
    idx_sum = CNT_W'(pidx_r) + d_r;
    if (idx_sum >= s_r) idx_sum = idx_sum - s_r;
    d_sum = d_r + CNT_W'(2);
    if (d_sum >= s_r) d_sum = d_sum - s_r;
  end

  always_comb begin
    state_nxt      = state_r;
    filled_nxt     = filled_r;
    clr_addr_nxt   = clr_addr_r;
    op_nxt         = op_r;
    key_nxt        = key_r;
    s_nxt          = s_r;
    kq_nxt         = kq_r;
    rem_nxt        = rem_r;
    div_cnt_nxt    = div_cnt_r;
    pidx_nxt       = pidx_r;
    d_nxt          = d_r;
    iss_cnt_nxt    = iss_cnt_r;
    p1_vld_nxt     = p1_vld_r;
    p1_idx_nxt     = p1_idx_r;
    res_status_nxt = res_status_r;
    res_slot_nxt   = res_slot_r;
    out_valid_nxt  = out_valid_r;
    out_status_nxt = out_status_r;
    out_slot_nxt   = out_slot_r;
    out_occ_nxt    = out_occ_r;
    out_half_nxt   = out_half_r;
    ram_we         = 1'b0;
    ram_waddr      = p1_idx_r;
    ram_wdata      = key_r;

    // Drop the output once the consumer takes it.
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      ST_CLEAR: begin
        // Sweep the store to empty, one slot a cycle.
        ram_we       = 1'b1;
        ram_waddr    = clr_addr_r;
        ram_wdata    = '0;
        clr_addr_nxt = clr_addr_r + IDX_W'(1);
        if (clr_addr_r == IDX_W'(CAPACITY - 1)) begin
          state_nxt = ST_IDLE;
        end
      end

      ST_IDLE: begin
        if (in_xfer) begin
          op_nxt  = in_op;
          key_nxt = in_key;
          s_nxt   = eff_size(tsize_r);
          if (in_key == '0 || in_op == 2'(OP_SEARCH) + 2'd1) begin
            res_status_nxt = STAT_INVALID;
            res_slot_nxt   = '0;
            state_nxt      = ST_RESP;
          end else begin
            kq_nxt      = DIV_W'(in_key);
            rem_nxt     = '0;
            div_cnt_nxt = '0;
            state_nxt   = ST_DIV;
          end
        end
      end

      ST_DIV: begin
        rem_nxt     = rem_step;
        kq_nxt      = kq_r << DIV_BITS;
        div_cnt_nxt = div_cnt_r + DIVC_W'(1);
        if (div_cnt_r == DIVC_W'(DIV_STEPS - 1)) begin
          // Home slot found: start probing at i = 0 with odd step 1.
          pidx_nxt    = rem_step;
          d_nxt       = CNT_W'(1);
          iss_cnt_nxt = '0;
          p1_vld_nxt  = 1'b0;
          state_nxt   = ST_PROBE;
        end
      end

      ST_PROBE: begin
        if (hit) begin
          res_status_nxt = STAT_OK;
          res_slot_nxt   = p1_idx_r;
          p1_vld_nxt     = 1'b0;
          state_nxt      = ST_RESP;
          if (op_r == OP_INSERT) begin
            ram_we     = 1'b1;
            ram_wdata  = key_r;
            filled_nxt = filled_r + CNT_W'(1);
          end else if (op_r == OP_DELETE) begin
            ram_we    = 1'b1;
            ram_wdata = '0;
            if (filled_r != '0) filled_nxt = filled_r - CNT_W'(1);
          end
        end else if (p1_vld_r && iss_cnt_r == s_r) begin
          // Last probe missed.
          res_status_nxt = (op_r == OP_INSERT) ? STAT_NO_FREE : STAT_NOT_FOUND;
          res_slot_nxt   = '0;
          p1_vld_nxt     = 1'b0;
          state_nxt      = ST_RESP;
        end else if (iss_cnt_r != s_r) begin
          // Issue the read at pidx_r and advance to the next probe.
          p1_vld_nxt  = 1'b1;
          p1_idx_nxt  = pidx_r;
          iss_cnt_nxt = iss_cnt_r + CNT_W'(1);
          pidx_nxt    = idx_sum[IDX_W-1:0];
          d_nxt       = d_sum;
        end else begin
          p1_vld_nxt = 1'b0;
        end
      end

      ST_RESP: begin
        // Hold until the output register is free.
        if (!out_valid_r || out_ready) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_status_r;
          out_slot_nxt   = res_slot_r;
          out_occ_nxt    = filled_r;
          out_half_nxt   = (filled_r > (s_r >> 1));
          state_nxt      = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      tsize_r     <= TSIZE_W'(TSIZE_RST);
      filled_r    <= '0;
      clr_addr_r  <= '0;
      p1_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      filled_r    <= filled_nxt;
      clr_addr_r  <= clr_addr_nxt;
      p1_vld_r    <= p1_vld_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        tsize_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    op_r         <= op_nxt;
    key_r        <= key_nxt;
    s_r          <= s_nxt;
    kq_r         <= kq_nxt;
    rem_r        <= rem_nxt;
    div_cnt_r    <= div_cnt_nxt;
    pidx_r       <= pidx_nxt;
    d_r          <= d_nxt;
    iss_cnt_r    <= iss_cnt_nxt;
    p1_idx_r     <= p1_idx_nxt;
    res_status_r <= res_status_nxt;
    res_slot_r   <= res_slot_nxt;
    out_status_r <= out_status_nxt;
    out_slot_r   <= out_slot_nxt;
    out_occ_r    <= out_occ_nxt;
    out_half_r   <= out_half_nxt;
  end

`ifndef NO_ASSERTIONS
  a_accept_moves_on: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer |=> (state_r == ST_DIV || state_r == ST_RESP))
    else $error("accepted request did not start");

  a_rem_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIV) |-> (CNT_W'(rem_r) < s_r))
    else $error("remainder not below table size");

  a_probe_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_PROBE) |-> (CNT_W'(pidx_r) < s_r && d_r < s_r))
    else $error("probe index or step out of table");

  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_CLEAR) |=> (filled_r == $past(filled_r) ||
                               filled_r == $past(filled_r) + CNT_W'(1) ||
                               filled_r == $past(filled_r) - CNT_W'(1)))
    else $error("occupancy changed by more than one");
`endif

endmodule

// ===== dv/quadratic_probe_hash_set_tb.sv =====
`timescale 1ns / 1ps

module quadratic_probe_hash_set_tb;
  import qphs_pkg::*;

  // Op code the block does not know; it must answer with an invalid status.
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

  // Largest key the 31-bit field can carry.
  localparam logic [KEY_W-1:0] KEY_MAX = {KEY_W{1'b1}};

  // Keep this many recent insert keys around so deletes and searches hit.
  localparam int unsigned POOL_DEPTH = 48;

  // After the last result, wait out one full-length probe chain to catch
  // any stray result.
  localparam int unsigned DRAIN_CYCLES = CAPACITY + 64;

  // Slowest correct run: about 800 requests, each probing the whole store at
  // the largest size, plus the block's own cycles, the longest sender gap and
  // receiver stall, plus the clearing pass. Take it five times over.
  localparam int unsigned TIMEOUT_CYCLES = 5 * (800 * (CAPACITY + 30) + 2 * CAPACITY);

  localparam int unsigned NUM_PHASES = 16;

  typedef struct packed {
    logic [OP_W-1:0]  op;
    logic [KEY_W-1:0] key;
  } request_t;

  typedef struct packed {
    status_t            status;
    logic [IDX_W-1:0]   slot;
    logic [CNT_W-1:0]   occupancy;
    logic               over_half;
  } hash_result_t;

  // Table sizes per random phase: primes, the full store size, the saturating
  // values below 3 and above the store, and the reset size. Big tables get few
  // requests, since every miss probes the whole table.
  int unsigned phase_size  [NUM_PHASES] = '{3, 5, 0, 7, 11, 13, 17, 31,
                                            61, 127, 2, 1021, 251, 1024, 2047, 29};
  int unsigned phase_items [NUM_PHASES] = '{60, 60, 30, 60, 60, 60, 60, 60,
                                            50, 40, 30, 15, 25, 10, 10, 60};

  logic                clk;
  logic                rst_n      = 1'b0;
  logic                in_valid   = 1'b0;
  logic                in_ready;
  logic [OP_W-1:0]     in_op      = '0;
  logic [KEY_W-1:0]    in_key     = '0;
  logic                out_valid;
  logic                out_ready  = 1'b0;
  logic [STAT_W-1:0]   out_status;
  logic [IDX_W-1:0]    out_slot_index;
  logic [CNT_W-1:0]    out_occupancy;
  logic                out_over_half;
  logic                cfg_valid  = 1'b0;
  logic                cfg_ready;
  logic [TSIZE_W-1:0]  cfg_data   = '0;

  // Shadow copy of the block's state and its one register.
  bit   [KEY_W-1:0]    shadow_slots [CAPACITY];
  int unsigned         shadow_count;
  logic [TSIZE_W-1:0]  table_size_cfg = TSIZE_W'(TSIZE_RST);

  request_t            pending_reqs [$];
  hash_result_t        expected_results [$];

  // Transfer counters, each written by one posedge process only.
  int unsigned         in_xfers;
  int unsigned         out_xfers;
  int unsigned         cfg_xfers;
  int unsigned         queued_total;
  int unsigned         fail_count;

  // Driver-side state.
  request_t            cur_req;
  bit                  req_live;
  int unsigned         in_seen;
  int unsigned         send_gap;
  int unsigned         out_seen;
  int unsigned         recv_stall;
  int unsigned         sender_idle_max = 5;
  int unsigned         recv_idle_max   = 5;

  quadratic_probe_hash_set i_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_op          (in_op),
    .in_key         (in_key),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_status     (out_status),
    .out_slot_index (out_slot_index),
    .out_occupancy  (out_occupancy),
    .out_over_half  (out_over_half),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_data       (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Walk the quadratic probe path (key + i*i) mod S over the shadow store,
  // update it the way the block must, and return the answer it must give.
  function automatic hash_result_t probe_table(input logic [OP_W-1:0] op,
                                               input logic [KEY_W-1:0] key);
    hash_result_t    res;
    int unsigned     span;
    int unsigned     i;
    longint unsigned pos;
    bit              hit;
    // Saturate the register to the usable range.
    span = 32'(table_size_cfg);
    if (span < MIN_SIZE) span = MIN_SIZE;
    if (span > CAPACITY) span = CAPACITY;
    res.status = STAT_INVALID;
    res.slot   = '0;
    hit        = 1'b0;
    if (key != '0 && (op == OP_INSERT || op == OP_DELETE || op == OP_SEARCH)) begin
      res.status = (op == OP_INSERT) ? STAT_NO_FREE : STAT_NOT_FOUND;
      // No tombstones: empty slots never end a delete or a search early.
      for (i = 0; i < span && !hit; i++) begin
        pos = 64'(key);
        pos = (pos + i * i) % span;
        if (op == OP_INSERT) begin
          if (shadow_slots[pos] == '0) begin
            shadow_slots[pos] = key;
            shadow_count++;
            hit = 1'b1;
          end
        end else if (shadow_slots[pos] == key) begin
          if (op == OP_DELETE) begin
            shadow_slots[pos] = '0;
            if (shadow_count > 0) shadow_count--;
          end
          hit = 1'b1;
        end
        if (hit) begin
          res.status = STAT_OK;
          res.slot   = pos[IDX_W-1:0];
        end
      end
    end
    res.occupancy = shadow_count[CNT_W-1:0];
    res.over_half = (shadow_count > span / 2);
    return res;
  endfunction

  task automatic queue_request(input logic [OP_W-1:0] op, input logic [KEY_W-1:0] key);
    request_t r;
    r.op  = op;
    r.key = key;
    pending_reqs.push_back(r);
    queued_total++;
  endtask

  // Hold until every queued request has been transferred and answered.
  // Sample at the falling edge, where no counter moves.
  task automatic wait_for_idle();
    while (in_xfers != queued_total || expected_results.size() != 0) @(negedge clk);
  endtask

  // Write the table size, hold valid until the transfer, then return on a
  // rising edge so that new requests land away from the driver's edge.
  task automatic write_table_size(input logic [TSIZE_W-1:0] size);
    int unsigned prev_xfers;
    prev_xfers = cfg_xfers;
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= size;
    while (cfg_xfers == prev_xfers) @(negedge clk);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Input side: every transfer updates the shadow state and queues the
  // answer the block owes for it.
  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready) begin
      expected_results.push_back(probe_table(in_op, in_key));
      in_xfers++;
    end
  end

  // Config side: track the register as the block takes it.
  always @(posedge clk) begin
    if (rst_n && cfg_valid && cfg_ready) begin
      table_size_cfg = cfg_data;
      cfg_xfers++;
    end
  end

  // Result side: compare every transfer with the oldest answer owed.
  always @(posedge clk) begin : result_check
    hash_result_t want;
    if (rst_n && out_valid && out_ready) begin
      out_xfers++;
      if (expected_results.size() == 0) begin
        $error("unexpected result: status %0d slot %0d occupancy %0d",
               out_status, out_slot_index, out_occupancy);
        fail_count++;
      end else begin
        want = expected_results.pop_front();
        if (out_status !== want.status) begin
          $error("out_status: expected %0d, got %0d", want.status, out_status);
          fail_count++;
        end
        if (out_slot_index !== want.slot) begin
          $error("out_slot_index: expected %0d, got %0d", want.slot, out_slot_index);
          fail_count++;
        end
        if (out_occupancy !== want.occupancy) begin
          $error("out_occupancy: expected %0d, got %0d", want.occupancy, out_occupancy);
          fail_count++;
        end
        if (out_over_half !== want.over_half) begin
          $error("out_over_half: expected %0d, got %0d", want.over_half, out_over_half);
          fail_count++;
        end
      end
    end
  end

  // Sender: after each transfer, idle a drawn number of cycles, then present
  // the next request. Valid and payload hold until the transfer; with no gap
  // valid simply stays high for the next request.
  always @(negedge clk) begin
    if (req_live && in_xfers != in_seen) begin
      in_seen  = in_xfers;
      req_live = 1'b0;
      send_gap = $urandom_range(0, sender_idle_max);
    end
    if (!req_live) begin
      if (send_gap > 0) begin
        send_gap--;
      end else if (pending_reqs.size() != 0) begin
        cur_req  = pending_reqs.pop_front();
        req_live = 1'b1;
      end
    end
    in_valid <= req_live;
    in_op    <= cur_req.op;
    in_key   <= cur_req.key;
  end

  // Receiver: after each result, stall a drawn number of cycles; count the
  // stall down only while a result is offered so it really backs up.
  always @(negedge clk) begin
    if (out_xfers != out_seen) begin
      out_seen   = out_xfers;
      recv_stall = $urandom_range(0, recv_idle_max);
    end else if (recv_stall > 0 && out_valid) begin
      recv_stall--;
    end
    out_ready <= (recv_stall == 0);
  end

  // Watchdog: end the run if the stimulus never completes.
  initial begin : watchdog
    int unsigned cycles;
    cycles = 0;
    while (cycles < TIMEOUT_CYCLES) begin
      @(posedge clk);
      cycles++;
    end
    $display("[quadratic_probe_hash_set] ERROR");
    $finish;
  end

  initial begin : stimulus
    logic [KEY_W-1:0] key_pool [$];
    logic [KEY_W-1:0] key;
    logic [OP_W-1:0]  op;
    int unsigned      ph;
    int unsigned      n;
    int unsigned      roll;
    int unsigned      shape;

    // Hold reset, then release it; the block then runs its clearing pass with
    // in_ready low, so the first requests simply wait for it.
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed, at the reset table size of 1021.
    queue_request(OP_INSERT, 31'd1);
    queue_request(OP_INSERT, KEY_MAX);
    queue_request(OP_INSERT, 31'd1);      // duplicate: a second copy is stored
    queue_request(OP_SEARCH, 31'd1);
    queue_request(OP_SEARCH, KEY_MAX);
    queue_request(OP_DELETE, 31'd1);      // clears the first copy only
    queue_request(OP_SEARCH, 31'd1);      // must skip the hole to the second copy
    queue_request(OP_DELETE, 31'd1);
    queue_request(OP_SEARCH, 31'd1);      // miss: full probe path
    queue_request(OP_DELETE, 31'd5);      // delete of an absent key
    queue_request(OP_INSERT, '0);         // zero key rejected for every op
    queue_request(OP_DELETE, '0);
    queue_request(OP_SEARCH, '0);
    queue_request(OP_UNUSED, 31'd7);      // unknown op
    wait_for_idle();

    // Smallest table. Offsets 0, 1, 4 reach only two of the three slots, so
    // a third insert on the same chain finds no free slot. The stale key from
    // the large table still counts toward occupancy.
    write_table_size(11'd3);
    queue_request(OP_INSERT, 31'd4);
    queue_request(OP_INSERT, 31'd7);
    queue_request(OP_INSERT, 31'd10);
    queue_request(OP_SEARCH, KEY_MAX);
    queue_request(OP_INSERT, 31'd3);
    queue_request(OP_DELETE, 31'd4);
    wait_for_idle();

    // All-ones register value saturates to the full store; the max key lands
    // in the last slot.
    write_table_size(11'd2047);
    queue_request(OP_SEARCH, KEY_MAX);
    queue_request(OP_INSERT, KEY_MAX);
    queue_request(OP_SEARCH, KEY_MAX);

    // Random phases. Each starts from an idle block, so the sender pauses
    // until every owed result has come before the new size is written.
    for (ph = 0; ph < NUM_PHASES; ph++) begin
      wait_for_idle();
      // Every third phase runs with no idling on either side.
      sender_idle_max = (ph % 3 == 2) ? 0 : 5;
      recv_idle_max   = (ph % 3 == 2) ? 0 : 5;
      write_table_size(TSIZE_W'(phase_size[ph]));
      for (n = 0; n < phase_items[ph]; n++) begin
        roll = $urandom_range(0, 99);
        if (roll < 3) begin
          queue_request(OP_W'($urandom_range(OP_INSERT, OP_SEARCH)), '0);
        end else if (roll < 6) begin
          key = KEY_W'($urandom);
          queue_request(OP_UNUSED, key);
        end else begin
          if (roll < 50) op = OP_INSERT;
          else if (roll < 75) op = OP_DELETE;
          else op = OP_SEARCH;
          // Deletes and searches mostly target known keys; inserts now and
          // then repeat one to stack duplicates.
          if (key_pool.size() != 0 &&
              ((op != OP_INSERT && $urandom_range(0, 3) != 0) ||
               (op == OP_INSERT && $urandom_range(0, 9) == 0))) begin
            key = key_pool[$urandom_range(0, key_pool.size() - 1)];
          end else begin
            shape = $urandom_range(0, 9);
            if (shape < 7) begin
              key = KEY_W'($urandom);
              if (key == '0) key = 31'd1;
            end else if (shape < 9) begin
              key = KEY_W'($urandom_range(1, 64));
            end else begin
              key = KEY_MAX - KEY_W'($urandom_range(0, 63));
            end
          end
          if (op == OP_INSERT) begin
            key_pool.push_back(key);
            if (key_pool.size() > POOL_DEPTH) key_pool.delete(0);
          end
          queue_request(op, key);
        end
      end
    end

    // Drain, then watch a while longer for stray results.
    wait_for_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("[quadratic_probe_hash_set] OK");
    end else begin
      $display("[quadratic_probe_hash_set] ERROR");
    end
    $finish;
  end

endmodule

// ===== files.f =====
design/qphs_pkg.sv
design/qphs_ram.sv
design/quadratic_probe_hash_set.sv
dv/quadratic_probe_hash_set_tb.sv
